// ===== sv/dgl_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package dgl_pkg;

    // Fixed-point constants (Q.32 scale factors, Q.16 values).
    localparam logic [31:0] LN2_Q32    = 32'd2977044472;
    localparam logic [32:0] LOG2E_Q32  = 33'd6196328019;
    localparam logic [16:0] LN_2PI_Q16 = 17'd120447;
    localparam int          EXP_HI     = 745000;
    localparam int          EXP_LO     = -20 * 65536;
    localparam int          EXP_STEPS  = 16;
    localparam int          LN_STEPS   = 16;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_LN,
        ST_LN_SCALE,
        ST_ACCUM,
        ST_SUM,
        ST_EXP_Y,
        ST_EXP_F,
        ST_EXP_OUT,
        ST_HOLD
    } dgl_state_t;

    typedef logic [EXP_STEPS-1:0][30:0] dgl_exp_table_t;

    function automatic logic [63:0] isqrt64(input logic [63:0] n_in);
        logic [63:0] n;
        logic [63:0] r;
        logic [63:0] b;
        n = n_in;
        r = 64'd0;
        b = 64'd1 << 62;
        for (int i = 0; i < 32; i++)
        begin
            if (b > n)
            begin
                b = b >> 2;
            end
        end
        for (int i = 0; i < 32; i++)
        begin
            if (b != 64'd0)
            begin
                if (n >= r + b)
                begin
                    n = n - (r + b);
                    r = (r >> 1) + b;
                end
                else
                begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
        end
        return r;
    endfunction

    // Factors 2^(2^-(i+1)) in Q1.30, each the truncated root of the one before.
    function automatic dgl_exp_table_t exp_table();
        dgl_exp_table_t t;
        logic [63:0] c;
        c = isqrt64(64'd2 << 60);
        for (int i = 0; i < EXP_STEPS; i++)
        begin
            t[i] = c[30:0];
            c = isqrt64(c << 30);
        end
        return t;
    endfunction

    // Saturate a 52-bit signed value to 48 bits; bit 48 of the result flags it.
    function automatic logic [48:0] sat48(input logic signed [51:0] v);
        logic [48:0] r;
        if (v > 52'sh7FFF_FFFF_FFFF)
        begin
            r = {1'b1, 48'h7FFF_FFFF_FFFF};
        end
        else if (v < -52'sh8000_0000_0000)
        begin
            r = {1'b1, 48'h8000_0000_0000};
        end
        else
        begin
            r = {1'b0, v[47:0]};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== sv/diagonal_gaussian_likelihood.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Non-final item: ready again only once the 48-step divider has finished, so a new
// item is not taken before the last is through; the 16-step logarithm runs beside it.
// Final item: the result is loaded and ready returns after the 16-step exponent
// (sooner when the log density skips the exponent), later if the output register is full.
// Reset (rst_n, asynchronous) clears the sums, the count, the overflow and output-valid
// flags and sets the variance floor to 66.
module diagonal_gaussian_likelihood
    import dgl_pkg::*;
#(
    parameter int MAX_DIM = 1024
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic [15:0] cfg_wr_data,   // variance_floor
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [23:0] feature_value, [47:24] mean_value, [71:48] variance_value
    input  wire logic [71:0] s_axis_tdata,
    input  wire logic        s_axis_tlast,  // last_element
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [47:0] log_likelihood, [79:48] likelihood, [90:80] element_count,
    // [91] saturated, [95:92] zero
    output logic [95:0]      m_axis_tdata
);

    localparam int CNT_W = $clog2(MAX_DIM + 1);
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_DIM);
    localparam dgl_exp_table_t EXP_C = exp_table();

    dgl_state_t state_reg, state_next;

    logic [15:0]            floor_reg;
    logic signed [47:0]     sq_sum_reg, sq_sum_next;
    logic signed [47:0]     ld_sum_reg, ld_sum_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic                   ovf_reg, ovf_next;

    logic [24:0]            d_reg;
    logic [23:0]            mag_reg;
    logic                   last_reg;
    logic [4:0]             p_reg;
    logic [30:0]            m_reg, m_next;
    logic [15:0]            frac_reg, frac_next;
    logic [3:0]             step_reg, step_next;
    logic signed [21:0]     ln_reg, ln_next;
    logic signed [47:0]     logp_reg, logp_next;
    logic                   sat_reg, sat_next;
    logic [15:0]            f_reg, f_next;
    logic [6:0]             kb_reg, kb_next;
    logic [31:0]            lik_reg, lik_next;

    logic                   out_valid_reg;
    logic [95:0]            out_data_reg;

    logic                   accept;
    logic                   load_out;

    // Input decode
    logic signed [24:0]     diff_in;
    logic [24:0]            mag_in;
    logic [24:0]            d_sum;
    logic [24:0]            d_in;
    logic [4:0]             p_in;

    // Shared multiplier
    logic [30:0]            mul_a;
    logic [32:0]            mul_b;
    logic [63:0]            prod;

    logic                   div_start;
    logic                   div_busy;
    logic [47:0]            quotient;

    logic signed [21:0]     l2;
    logic [20:0]            l2_mag;
    logic [20:0]            logp_mag;
    logic [63:0]            rnd_prod;
    logic [22:0]            y_mag;
    logic signed [23:0]     y_s;
    logic [23:0]            yb;
    logic [31:0]            ln_sq;

    logic signed [51:0]     sq_acc;
    logic signed [51:0]     ld_acc;
    logic [48:0]            sq_sat;
    logic [48:0]            ld_sat;
    logic signed [51:0]     total;
    logic signed [51:0]     t_neg;
    logic [48:0]            logp_sat;

    logic [6:0]             sh_r;
    logic [1:0]             sh_l;
    logic [63:0]            up_val;
    logic [63:0]            dn_val;
    logic [10:0]            cnt_ext;

    assign accept        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign load_out      = (state_reg == ST_HOLD) && (!out_valid_reg || m_axis_tready);

    assign diff_in = 25'(signed'(s_axis_tdata[23:0])) - 25'(signed'(s_axis_tdata[47:24]));
    assign mag_in  = diff_in[24] ? 25'(-diff_in) : 25'(diff_in);
    assign d_sum   = {1'b0, s_axis_tdata[71:48]} + {9'd0, floor_reg};
    assign d_in    = (d_sum == 25'd0) ? 25'd1 : d_sum;

    always_comb
    begin
        p_in = 5'd0;
        for (int i = 0; i < 25; i++)
        begin
            if (d_in[i])
            begin
                p_in = 5'(i);
            end
        end
    end

    // Operand selection for the one multiplier
    assign l2       = {6'(signed'({1'b0, p_reg}) - 6'sd16), frac_reg};
    assign l2_mag   = l2[21] ? 21'(-l2) : 21'(l2);
    assign logp_mag = logp_reg[47] ? 21'(-logp_reg) : 21'(logp_reg);

    always_comb
    begin
        mul_a = 31'd0;
        mul_b = 33'd0;
        case (state_reg)
            ST_SQUARE:
            begin
                mul_a = {7'd0, mag_reg};
                mul_b = {9'd0, mag_reg};
            end
            ST_LN:
            begin
                mul_a = m_reg;
                mul_b = {2'd0, m_reg};
            end
            ST_LN_SCALE:
            begin
                mul_a = {10'd0, l2_mag};
                mul_b = {1'b0, LN2_Q32};
            end
            ST_EXP_Y:
            begin
                mul_a = {10'd0, logp_mag};
                mul_b = LOG2E_Q32;
            end
            ST_EXP_F:
            begin
                mul_a = m_reg;
                mul_b = {2'd0, EXP_C[step_reg]};
            end
            default:
            begin
                mul_a = 31'd0;
                mul_b = 33'd0;
            end
        endcase
    end

    assign prod     = 64'(mul_a) * 64'(mul_b);
    assign rnd_prod = prod + 64'h8000_0000;
    assign y_mag    = rnd_prod[54:32];
    assign y_s      = logp_reg[47] ? -24'(signed'({1'b0, y_mag})) : 24'(signed'({1'b0, y_mag}));
    assign yb       = 24'(y_s) + 24'h40_0000;
    assign ln_sq    = prod[61:30];

    assign div_start = (state_reg == ST_SQUARE);

    dgl_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (prod[47:0]),
        .divisor  (d_reg),
        .busy     (div_busy),
        .quotient (quotient)
    );

    assign sq_acc   = 52'(sq_sum_reg) + 52'(signed'({4'd0, quotient}));
    assign ld_acc   = 52'(ld_sum_reg) + 52'(ln_reg);
    assign sq_sat   = sat48(sq_acc);
    assign ld_sat   = sat48(ld_acc);
    assign total    = 52'(sq_sum_reg) + 52'(ld_sum_reg)
                      + 52'(signed'({1'b0, 52'(cnt_reg) * 52'(LN_2PI_Q16)}));
    assign t_neg    = -total;
    assign logp_sat = sat48(t_neg >>> 1);

    // Exponent 2^k scaling: shift by (yb[22:16] - 78) with half-up rounding.
    assign sh_l   = 2'(kb_reg - 7'd78);
    assign sh_r   = 7'd78 - kb_reg;
    assign up_val = 64'(m_reg) << sh_l;
    assign dn_val = (64'(m_reg) + (64'd1 << (sh_r - 7'd1))) >> sh_r;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:     state_next = accept ? ST_SQUARE : ST_IDLE;
            ST_SQUARE:   state_next = ST_LN;
            ST_LN:       state_next = (step_reg == 4'(LN_STEPS - 1)) ? ST_LN_SCALE : ST_LN;
            ST_LN_SCALE: state_next = ST_ACCUM;
            ST_ACCUM:
            begin
                if (!div_busy)
                begin
                    state_next = last_reg ? ST_SUM : ST_IDLE;
                end
            end
            ST_SUM:      state_next = ST_EXP_Y;
            ST_EXP_Y:
            begin
                if (logp_reg > 48'sd745000 || logp_reg < -48'sd1310720)
                begin
                    state_next = ST_HOLD;
                end
                else
                begin
                    state_next = ST_EXP_F;
                end
            end
            ST_EXP_F:    state_next = (step_reg == 4'(EXP_STEPS - 1)) ? ST_EXP_OUT : ST_EXP_F;
            ST_EXP_OUT:  state_next = ST_HOLD;
            ST_HOLD:     state_next = load_out ? ST_IDLE : ST_HOLD;
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        sq_sum_next = sq_sum_reg;
        ld_sum_next = ld_sum_reg;
        cnt_next    = cnt_reg;
        ovf_next    = ovf_reg;
        m_next      = m_reg;
        frac_next   = frac_reg;
        step_next   = step_reg;
        ln_next     = ln_reg;
        logp_next   = logp_reg;
        sat_next    = sat_reg;
        f_next      = f_reg;
        kb_next     = kb_reg;
        lik_next    = lik_reg;
        case (state_reg)
            ST_IDLE:
            begin
                m_next    = 31'(d_in) << (5'd30 - p_in);
                frac_next = 16'd0;
                step_next = 4'd0;
            end
            ST_LN:
            begin
                step_next = step_reg + 4'd1;
                if (ln_sq[31])
                begin
                    m_next    = ln_sq[31:1];
                    frac_next = {frac_reg[14:0], 1'b1};
                end
                else
                begin
                    m_next    = ln_sq[30:0];
                    frac_next = {frac_reg[14:0], 1'b0};
                end
            end
            ST_LN_SCALE:
            begin
                ln_next = l2[21] ? -22'(signed'({1'b0, rnd_prod[52:32]}))
                                 : 22'(signed'({1'b0, rnd_prod[52:32]}));
            end
            ST_ACCUM:
            begin
                if (!div_busy)
                begin
                    sq_sum_next = sq_sat[47:0];
                    ld_sum_next = ld_sat[47:0];
                    if (cnt_reg < MAX_CNT)
                    begin
                        cnt_next = cnt_reg + CNT_W'(1);
                        ovf_next = ovf_reg | sq_sat[48] | ld_sat[48];
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                end
            end
            ST_SUM:
            begin
                logp_next = logp_sat[47:0];
                sat_next  = ovf_reg | logp_sat[48];
            end
            ST_EXP_Y:
            begin
                m_next    = 31'h4000_0000;
                step_next = 4'd0;
                f_next    = yb[15:0];
                kb_next   = yb[22:16];
                if (logp_reg > 48'sd745000)
                begin
                    lik_next = 32'hFFFF_FFFF;
                    sat_next = 1'b1;
                end
                else
                begin
                    lik_next = 32'd0;
                end
            end
            ST_EXP_F:
            begin
                step_next = step_reg + 4'd1;
                if (f_reg[4'(EXP_STEPS - 1) - step_reg])
                begin
                    m_next = prod[60:30];
                end
            end
            ST_EXP_OUT:
            begin
                if (kb_reg >= 7'd78)
                begin
                    if (up_val > 64'hFFFF_FFFF)
                    begin
                        lik_next = 32'hFFFF_FFFF;
                        sat_next = 1'b1;
                    end
                    else
                    begin
                        lik_next = up_val[31:0];
                    end
                end
                else if (sh_r >= 7'd63)
                begin
                    lik_next = 32'd0;
                end
                else
                begin
                    lik_next = dn_val[31:0];
                end
            end
            ST_HOLD:
            begin
                if (load_out)
                begin
                    sq_sum_next = 48'sd0;
                    ld_sum_next = 48'sd0;
                    cnt_next    = '0;
                    ovf_next    = 1'b0;
                end
            end
            default:
            begin
                sq_sum_next = sq_sum_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            floor_reg     <= 16'd66;
            sq_sum_reg    <= 48'sd0;
            ld_sum_reg    <= 48'sd0;
            cnt_reg       <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            sq_sum_reg <= sq_sum_next;
            ld_sum_reg <= ld_sum_next;
            cnt_reg    <= cnt_next;
            ovf_reg    <= ovf_next;
            if (cfg_wr_en)
            begin
                floor_reg <= cfg_wr_data;
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign cnt_ext = 11'(cnt_reg);

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            d_reg    <= d_in;
            mag_reg  <= mag_in[23:0];
            last_reg <= s_axis_tlast;
            p_reg    <= p_in;
        end
        m_reg    <= m_next;
        frac_reg <= frac_next;
        step_reg <= step_next;
        ln_reg   <= ln_next;
        logp_reg <= logp_next;
        sat_reg  <= sat_next;
        f_reg    <= f_next;
        kb_reg   <= kb_next;
        lik_reg  <= lik_next;
        if (load_out)
        begin
            out_data_reg <= {4'd0, sat_reg, cnt_ext, lik_reg, logp_reg};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    a_ready_only_when_divider_idle: assert property (
        @(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> !div_busy
    ) else $error("input taken while the divider is busy");

    a_busy_after_accept: assert property (
        @(posedge clk) disable iff (!rst_n)
        accept |=> !s_axis_tready
    ) else $error("second item taken straight after the first");

    a_count_bounded: assert property (
        @(posedge clk) disable iff (!rst_n)
        cnt_reg <= MAX_CNT
    ) else $error("element count above the maximum dimension");

    a_load_frees_output: assert property (
        @(posedge clk) disable iff (!rst_n)
        load_out |=> (m_axis_tvalid && cnt_reg == '0 && !ovf_reg)
    ) else $error("result load did not clear the accumulators");

endmodule

`default_nettype wire

// ===== sv/dgl_div.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dgl_div (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [47:0] dividend,
    input  wire logic [24:0] divisor,
    output logic             busy,
    output logic [47:0]      quotient
);

    localparam logic [5:0] LAST_STEP = 6'd47;

    logic [24:0] rem_reg, rem_next;
    logic [47:0] quo_reg, quo_next;
    logic [24:0] dvs_reg;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [25:0] trial;
    logic [25:0] diff;
    logic        ge;

    // Restoring division, one quotient bit per cycle; the dividend shifts out
    // of the top of the quotient register as quotient bits shift in.
    assign trial = {rem_reg, quo_reg[47]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign ge    = trial >= {1'b0, dvs_reg};

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            rem_next  = 25'd0;
            quo_next  = dividend;
            cnt_next  = LAST_STEP;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff[24:0] : trial[24:0];
            quo_next = {quo_reg[46:0], ge};
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd0)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= 6'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (start)
        begin
            dvs_reg <= divisor;
        end
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire
